// ----- rtl/core/skvt_pkg.sv -----
package skvt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 32;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int EIDX_W = 6;
    localparam int EXT_W  = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;
    localparam int FLAG_W = 2;

    typedef enum logic [2:0] {
        CMD_REGISTER  = 3'd0,
        CMD_GET       = 3'd1,
        CMD_USER_SET  = 3'd2,
        CMD_SIM_SET   = 3'd3,
        CMD_UNCHECKED = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_READONLY     = 3'd2,
        ST_SIM_UNROUTED = 3'd3,
        ST_FULL         = 3'd4,
        ST_DUPLICATE    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_COMPARE,
        S_SHIFT,
        S_SHIFT_WR,
        S_INSERT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [31:0] value;
        logic        readonly_flag;
        logic        sim_flag;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_data;
        logic [5:0]  entry_index;
    } rsp_word_t;

    // memory requests from the controller
    typedef struct packed {
        logic              order_we;
        logic [IDX_W-1:0]  order_waddr;
        logic [IDX_W-1:0]  order_wdata;
        logic [IDX_W-1:0]  order_raddr;
        logic              ent_we;
        logic [IDX_W-1:0]  ent_waddr;
        logic [KEY_W-1:0]  ent_key;
        logic [FLAG_W-1:0] ent_flags;
        logic [IDX_W-1:0]  ent_raddr;
        logic              val_we;
        logic [IDX_W-1:0]  val_waddr;
        logic [31:0]       val_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  order_rdata;
        logic [KEY_W-1:0]  key_rdata;
        logic [31:0]       val_rdata;
        logic [FLAG_W-1:0] flag_rdata;
    } mem_rsp_t;

    function automatic logic [EIDX_W-1:0] to_eidx(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(idx);
        return ext[EIDX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/skvt_ram.sv -----
module skvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/skvt_ctrl.sv -----
module skvt_ctrl
    import skvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp,
    output mem_req_t  mreq,
    input  mem_rsp_t  mrsp
);

    state_t state_reg, state_next;

    logic [2:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [31:0]       value_reg, value_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           res_status_reg, res_status_next;
    logic [31:0]       res_data_reg, res_data_next;
    logic [EIDX_W-1:0] res_eidx_reg, res_eidx_next;
    rsp_word_t         rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic             accept;
    logic             cmd_known;
    logic             table_full;
    logic             hit;
    logic             rsp_free;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] ptr_dec;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec    = ptr_reg - CNT_W'(1);
    assign hit        = (mrsp.key_rdata == key_reg);

    always_comb
    begin
        cmd_known = req.command inside {CMD_REGISTER, CMD_GET, CMD_USER_SET,
                                        CMD_SIM_SET, CMD_UNCHECKED};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!cmd_known || (req.command == CMD_REGISTER && table_full))
                        state_next = S_FINISH;
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                    state_next = S_FETCH;
                else if (cmd_reg == CMD_REGISTER)
                    state_next = S_SHIFT;
                else
                    state_next = S_FINISH;
            end
            S_FETCH:    state_next = S_COMPARE;
            S_COMPARE:  state_next = hit ? S_FINISH : S_SEARCH;
            S_SHIFT:    state_next = (ptr_reg > lo_reg) ? S_SHIFT_WR : S_INSERT;
            S_SHIFT_WR: state_next = S_SHIFT;
            S_INSERT:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        flags_next      = flags_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_eidx_next   = res_eidx_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        mreq             = '0;
        mreq.order_raddr = mid[IDX_W-1:0];
        mreq.ent_raddr   = mrsp.order_rdata;
        mreq.ent_key     = key_reg;
        mreq.ent_flags   = flags_reg;
        mreq.val_wdata   = value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = req.command;
                    key_next        = req.key[KEY_W-1:0];
                    value_next      = req.value;
                    flags_next      = {req.sim_flag, req.readonly_flag};
                    lo_next         = '0;
                    hi_next         = count_reg;
                    res_status_next = ST_NOT_FOUND;
                    res_data_next   = '0;
                    res_eidx_next   = '0;
                    if (req.command == CMD_REGISTER && table_full)
                        res_status_next = ST_FULL;
                end
            end
            S_SEARCH:
            begin
                mid_next = mid;
                ptr_next = count_reg;
            end
            S_FETCH:
            begin
                idx_next = mrsp.order_rdata;
            end
            S_COMPARE:
            begin
                if (hit)
                begin
                    res_eidx_next = to_eidx(idx_reg);
                    mreq.val_waddr = idx_reg;
                    case (cmd_reg)
                        CMD_REGISTER:
                            res_status_next = ST_DUPLICATE;
                        CMD_GET:
                        begin
                            res_status_next = ST_OK;
                            res_data_next   = mrsp.val_rdata;
                        end
                        CMD_USER_SET:
                        begin
                            if (mrsp.flag_rdata[0])
                                res_status_next = ST_READONLY;
                            else if (mrsp.flag_rdata[1])
                                res_status_next = ST_SIM_UNROUTED;
                            else
                            begin
                                res_status_next = ST_OK;
                                mreq.val_we     = 1'b1;
                            end
                        end
                        CMD_SIM_SET:
                        begin
                            if (mrsp.flag_rdata[0])
                                res_status_next = ST_READONLY;
                            else
                            begin
                                res_status_next = ST_OK;
                                mreq.val_we     = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                            mreq.val_we     = 1'b1;
                        end
                    endcase
                end
                else if (mrsp.key_rdata < key_reg)
                    lo_next = mid_reg + CNT_W'(1);
                else
                    hi_next = mid_reg;
            end
            S_SHIFT:
            begin
                mreq.order_raddr = ptr_dec[IDX_W-1:0];
            end
            S_SHIFT_WR:
            begin
                // move one order slot up toward the end
                mreq.order_we    = 1'b1;
                mreq.order_waddr = ptr_reg[IDX_W-1:0];
                mreq.order_wdata = mrsp.order_rdata;
                ptr_next         = ptr_dec;
            end
            S_INSERT:
            begin
                // lo is the insertion point left by the failed search
                mreq.order_we    = 1'b1;
                mreq.order_waddr = lo_reg[IDX_W-1:0];
                mreq.order_wdata = count_reg[IDX_W-1:0];
                mreq.ent_we      = 1'b1;
                mreq.ent_waddr   = count_reg[IDX_W-1:0];
                mreq.val_we      = 1'b1;
                mreq.val_waddr   = count_reg[IDX_W-1:0];
                count_next       = count_reg + CNT_W'(1);
                res_status_next  = ST_OK;
                res_eidx_next    = to_eidx(count_reg[IDX_W-1:0]);
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_next.status      = res_status_reg;
                    rsp_next.read_data   = res_data_reg;
                    rsp_next.entry_index = res_eidx_reg;
                    rsp_valid_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        flags_reg      <= flags_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_eidx_reg   <= res_eidx_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ----- rtl/core/sorted_key_value_table.sv -----
// channel | valid     | ready     | word
// request | req_valid | req_ready | req (command, key, value, readonly_flag, sim_flag)
// response| rsp_valid | rsp_ready | rsp (status, read_data, entry_index)
//
// one word in flight; a lookup probe reads the order store, then the entry, then compares keys;
// at most ceil(log2(n+1)) probes for n entries
// a new register moves each order slot above the insertion point up by one, then inserts the entry
// reset clears the entry count and the handshake state; the memories keep their contents
// the next word is taken while a result waits in the response register
// a finished word holds in the controller until the response register frees up
module sorted_key_value_table
    import skvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    mem_req_t mreq;
    mem_rsp_t mrsp;

    skvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mreq      (mreq),
        .mrsp      (mrsp)
    );

    // order store: arrival indices sorted by key
    skvt_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_order_ram (
        .clk   (clk),
        .we    (mreq.order_we),
        .waddr (mreq.order_waddr),
        .wdata (mreq.order_wdata),
        .raddr (mreq.order_raddr),
        .rdata (mrsp.order_rdata)
    );

    skvt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (mreq.ent_we),
        .waddr (mreq.ent_waddr),
        .wdata (mreq.ent_key),
        .raddr (mreq.ent_raddr),
        .rdata (mrsp.key_rdata)
    );

    skvt_ram #(.WIDTH(FLAG_W), .DEPTH(TABLE_DEPTH)) u_flag_ram (
        .clk   (clk),
        .we    (mreq.ent_we),
        .waddr (mreq.ent_waddr),
        .wdata (mreq.ent_flags),
        .raddr (mreq.ent_raddr),
        .rdata (mrsp.flag_rdata)
    );

    skvt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (mreq.val_we),
        .waddr (mreq.val_waddr),
        .wdata (mreq.val_wdata),
        .raddr (mreq.ent_raddr),
        .rdata (mrsp.val_rdata)
    );

endmodule

// ----- rtl/core/skvt_checker.sv -----
module skvt_checker
    import skvt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input req_word_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_word_t rsp
);

    // a waiting request holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request word changed while waiting");

    // a stalled response holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

    // only one word is worked on at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while a word is in flight");

    // read data is only returned by a successful get
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
    else $error("read data on a failed command");

    // no entry is named when the key is missing or the table is full
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
        |-> rsp.entry_index == '0)
    else $error("entry index on a miss");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
